### rtl/hfgc_pkg.sv
// Shared constants, curve tables and pipeline types for the frequency gain curve.
package hfgc_pkg;

    localparam int TABLE_POINTS = 9;
    localparam int FREQ_W       = 16;
    localparam int FEEL_W       = 12;
    localparam int GAIN_W       = 12;
    localparam int GAIN_FRAC    = 8;
    localparam int CFG_IDX_W    = 3;
    localparam int IDX_W        = $clog2(TABLE_POINTS);
    localparam int CNT_W        = $clog2(TABLE_POINTS + 1);

    // Divider cells: divisor is a feel or a table span, both fit FEEL_W bits.
    localparam int DIV_W         = FEEL_W;
    localparam int NUM_W         = FEEL_W + DIV_W;
    localparam int QUO_W         = NUM_W;
    localparam int INTERP_STEPS  = NUM_W;
    localparam int GAIN_STEPS    = FEEL_W + GAIN_FRAC;

    typedef logic [FREQ_W-1:0] t_freq;
    typedef logic [FEEL_W-1:0] t_feel;
    typedef logic [GAIN_W-1:0] t_gain;

    localparam t_gain UNITY_GAIN = GAIN_W'(256);

    localparam t_freq CURVE_FREQ [TABLE_POINTS] = '{
        16'd8883,  16'd10317, 16'd11187, 16'd11750, 16'd14618,
        16'd16051, 16'd18918, 16'd21786, 16'd24653
    };
    localparam t_feel CURVE_FEEL [TABLE_POINTS] = '{
        12'd1280, 12'd2048, 12'd2560, 12'd2048, 12'd256,
        12'd512,  12'd768,  12'd768,  12'd768
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENABLE   = CFG_IDX_W'(0),
        REG_TARGET   = CFG_IDX_W'(1),
        REG_MIN_FEEL = CFG_IDX_W'(2),
        REG_MIN_GAIN = CFG_IDX_W'(3),
        REG_MAX_GAIN = CFG_IDX_W'(4)
    } t_cfg_reg;

    // Values that ride along with a request through the divider cells.
    typedef struct packed {
        logic  bypass;
        logic  neg;
        t_feel base;
    } t_side;

    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [DIV_W-1:0] rem;
        logic [DIV_W-1:0] dvsr;
        logic [QUO_W-1:0] quo;
        t_side            side;
    } t_div;

endpackage

### rtl/hfgc_div_cell.sv
// One restoring-division cell: resolves one quotient bit and hands the request on.
module hfgc_div_cell import hfgc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_div i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_div o_data
);

    logic           r_valid;
    t_div           r_data;
    t_div           n_data;
    logic [DIV_W:0] trial;
    logic           take;

    always_comb begin
        trial  = {i_data.rem, i_data.num[NUM_W-1]};
        take   = trial >= {1'b0, i_data.dvsr};
        n_data = i_data;
        n_data.num = i_data.num << 1;
        n_data.rem = take ? DIV_W'(trial - {1'b0, i_data.dvsr}) : trial[DIV_W-1:0];
        n_data.quo = {i_data.quo[QUO_W-2:0], take};
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_data <= n_data;
        end
    end

endmodule

### rtl/hfgc_lookup.sv
// Segment search, table read and slope product ahead of the interpolation divider.
module hfgc_lookup import hfgc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_freq i_frequency,
    input  logic  i_enable,
    output logic  o_valid,
    input  logic  i_ready,
    output t_div  o_data
);

    // Stage 0: compare against every table point
    logic                    r0_v;
    t_freq                   r0_x;
    logic [TABLE_POINTS-1:0] r0_lt;
    logic                    r0_bypass;
    logic [TABLE_POINTS-1:0] n0_lt;

    // Stage 1: segment operands
    logic              r1_v;
    t_feel             r1_mag;
    logic [DIV_W-1:0]  r1_dx;
    logic [DIV_W-1:0]  r1_span;
    t_side             r1_side;

    // Stage 2: slope product
    logic r2_v;
    t_div r2_data;

    logic ready0, ready1, ready2;

    logic [CNT_W-1:0] cnt;
    logic             lo_end, hi_end;
    logic [IDX_W-1:0] hi_idx, lo_idx;
    t_feel            f_lo, f_hi;
    t_freq            x_lo, span_full, dx_full;
    t_feel            n1_mag;
    logic [DIV_W-1:0] n1_dx;
    t_side            n1_side;
    t_div             n2_data;

    assign ready2  = !r2_v || i_ready;
    assign ready1  = !r1_v || ready2;
    assign ready0  = !r0_v || ready1;
    assign o_ready = ready0;
    assign o_valid = r2_v;
    assign o_data  = r2_data;

    always_comb begin
        for (int i = 0; i < TABLE_POINTS; i++) begin
            n0_lt[i] = CURVE_FREQ[i] < i_frequency;
        end
    end

    always_comb begin
        cnt    = CNT_W'($countones(r0_lt));
        lo_end = cnt == '0;
        hi_end = cnt == CNT_W'(TABLE_POINTS);
        if (lo_end) begin
            hi_idx = IDX_W'(1);
        end else if (hi_end) begin
            hi_idx = IDX_W'(TABLE_POINTS - 1);
        end else begin
            hi_idx = cnt[IDX_W-1:0];
        end
        lo_idx    = hi_idx - IDX_W'(1);
        f_lo      = CURVE_FEEL[lo_idx];
        f_hi      = CURVE_FEEL[hi_idx];
        x_lo      = CURVE_FREQ[lo_idx];
        span_full = CURVE_FREQ[hi_idx] - x_lo;
        dx_full   = r0_x - x_lo;

        n1_side.bypass = r0_bypass;
        n1_side.neg    = f_hi < f_lo;
        n1_side.base   = hi_end ? f_hi : f_lo;
        n1_mag         = n1_side.neg ? (f_lo - f_hi) : (f_hi - f_lo);
        n1_dx          = dx_full[DIV_W-1:0];
        // Outside the table: zero product, the end value passes unchanged
        if (lo_end || hi_end) begin
            n1_mag = '0;
            n1_dx  = '0;
        end
    end

    always_comb begin
        n2_data.num  = NUM_W'(r1_mag) * NUM_W'(r1_dx);
        n2_data.rem  = '0;
        n2_data.dvsr = r1_span;
        n2_data.quo  = '0;
        n2_data.side = r1_side;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
            r1_v <= 1'b0;
            r2_v <= 1'b0;
        end else begin
            if (ready0) begin
                r0_v <= i_valid;
            end
            if (ready1) begin
                r1_v <= r0_v;
            end
            if (ready2) begin
                r2_v <= r1_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && ready0) begin
            r0_x      <= i_frequency;
            r0_lt     <= n0_lt;
            r0_bypass <= (i_frequency == '0) || !i_enable;
        end
        if (r0_v && ready1) begin
            r1_mag  <= n1_mag;
            r1_dx   <= n1_dx;
            r1_span <= span_full[DIV_W-1:0];
            r1_side <= n1_side;
        end
        if (r1_v && ready2) begin
            r2_data <= n2_data;
        end
    end

endmodule

### rtl/haptic_frequency_gain_curve_core.sv
// Top level of the frequency gain curve: configuration, two divider chains, output clamp.
// Maps a Q8.8 frequency to a Q4.8 gain: the felt strength is interpolated from a
// fixed 9-point curve, floored at min_feel, and target_feel is divided by it, then
// clamped to [min_gain, max_gain]; zero frequency or a cleared enable gives 256.
// One request is taken per clock while o_stall is low; each result passes through
// three lookup stages, a 24-cell interpolation divider, one feel stage, a 20-cell
// gain divider and the output register, each cell resolving one quotient bit.
// Stalls back up stage by stage, so empty stages still fill while a result waits.
// Configuration is written through a port that is always ready; indexes past the
// last register are ignored.
module haptic_frequency_gain_curve_core import hfgc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  t_freq                i_frequency,
    output logic                 o_valid,
    input  logic                 i_stall,
    output t_gain                o_gain,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [FEEL_W-1:0]    i_cfg_data
);

    logic  r_enable;
    t_feel r_target_feel;
    t_feel r_min_feel;
    t_gain r_min_gain;
    t_gain r_max_gain;

    logic a_v [INTERP_STEPS+1];
    logic a_r [INTERP_STEPS+1];
    t_div a_d [INTERP_STEPS+1];
    logic b_v [GAIN_STEPS+1];
    logic b_r [GAIN_STEPS+1];
    t_div b_d [GAIN_STEPS+1];

    logic  r_mid_v;
    t_div  r_mid;
    t_div  n_mid;
    t_feel q_feel, feel, floored;

    logic                  r_out_v;
    t_gain                 r_gain;
    t_gain                 n_gain;
    logic [GAIN_STEPS-1:0] g;
    logic                  lookup_ready;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable      <= 1'b0;
            r_target_feel <= FEEL_W'(1280);
            r_min_feel    <= FEEL_W'(128);
            r_min_gain    <= GAIN_W'(128);
            r_max_gain    <= GAIN_W'(1024);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_ENABLE:   r_enable      <= i_cfg_data[0];
                REG_TARGET:   r_target_feel <= i_cfg_data;
                REG_MIN_FEEL: r_min_feel    <= i_cfg_data;
                REG_MIN_GAIN: r_min_gain    <= i_cfg_data;
                REG_MAX_GAIN: r_max_gain    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    hfgc_lookup u_lookup (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (lookup_ready),
        .i_frequency (i_frequency),
        .i_enable    (r_enable),
        .o_valid     (a_v[0]),
        .i_ready     (a_r[0]),
        .o_data      (a_d[0])
    );

    assign o_stall = !lookup_ready;

    for (genvar k = 0; k < INTERP_STEPS; k++) begin : g_interp
        hfgc_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (a_v[k]),
            .o_ready (a_r[k]),
            .i_data  (a_d[k]),
            .o_valid (a_v[k+1]),
            .i_ready (a_r[k+1]),
            .o_data  (a_d[k+1])
        );
    end

    // Finish the interpolation, floor the feel, and form the gain dividend
    always_comb begin
        q_feel  = a_d[INTERP_STEPS].quo[FEEL_W-1:0];
        feel    = a_d[INTERP_STEPS].side.neg ? (a_d[INTERP_STEPS].side.base - q_feel)
                                             : (a_d[INTERP_STEPS].side.base + q_feel);
        floored = (feel < r_min_feel) ? r_min_feel : feel;
        if (floored == '0) begin
            floored = FEEL_W'(1);
        end
        n_mid.num  = {r_target_feel, {(NUM_W - FEEL_W){1'b0}}};
        n_mid.rem  = '0;
        n_mid.dvsr = floored;
        n_mid.quo  = '0;
        n_mid.side = a_d[INTERP_STEPS].side;
    end

    assign a_r[INTERP_STEPS] = !r_mid_v || b_r[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid_v <= 1'b0;
        end else if (a_r[INTERP_STEPS]) begin
            r_mid_v <= a_v[INTERP_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_v[INTERP_STEPS] && a_r[INTERP_STEPS]) begin
            r_mid <= n_mid;
        end
    end

    assign b_v[0] = r_mid_v;
    assign b_d[0] = r_mid;

    for (genvar k = 0; k < GAIN_STEPS; k++) begin : g_gain
        hfgc_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (b_v[k]),
            .o_ready (b_r[k]),
            .i_data  (b_d[k]),
            .o_valid (b_v[k+1]),
            .i_ready (b_r[k+1]),
            .o_data  (b_d[k+1])
        );
    end

    // Bypass gives unity gain; otherwise clamp against min_gain first, then max_gain
    always_comb begin
        g = b_d[GAIN_STEPS].quo[GAIN_STEPS-1:0];
        if (b_d[GAIN_STEPS].side.bypass) begin
            n_gain = UNITY_GAIN;
        end else if (g < GAIN_STEPS'(r_min_gain)) begin
            n_gain = r_min_gain;
        end else if (g > GAIN_STEPS'(r_max_gain)) begin
            n_gain = r_max_gain;
        end else begin
            n_gain = g[GAIN_W-1:0];
        end
    end

    assign b_r[GAIN_STEPS] = !r_out_v || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (b_r[GAIN_STEPS]) begin
            r_out_v <= b_v[GAIN_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_v[GAIN_STEPS] && b_r[GAIN_STEPS]) begin
            r_gain <= n_gain;
        end
    end

    assign o_valid = r_out_v;
    assign o_gain  = r_gain;

    // Input backs up only when the output side is stalled
    a_stall_from_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> i_stall)
        else $error("input stalled while output not stalled");

    // Interpolation quotient fits in FEEL_W bits (it never exceeds the segment's feel difference)
    a_interp_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        a_v[INTERP_STEPS] |-> (a_d[INTERP_STEPS].quo[QUO_W-1:FEEL_W] == '0))
        else $error("interpolation quotient overflow");

    a_divisor_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mid_v |-> (r_mid.dvsr != '0))
        else $error("zero divisor entered gain divider");

    a_gain_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (r_min_gain <= r_max_gain)) |->
            ((o_gain == UNITY_GAIN) || ((o_gain >= r_min_gain) && (o_gain <= r_max_gain))))
        else $error("gain outside clamp limits");

endmodule
